@@ src/hfc_pkg.sv @@
// hfc_pkg: shared constants for the half/single converter.
// No dependencies; used by every module under src.
package hfc_pkg;

    // conversion direction codes
    localparam logic ACT_WIDEN  = 1'b0;   // half to single
    localparam logic ACT_NARROW = 1'b1;   // single to half

    // largest finite half magnitude, in each format
    localparam logic [30:0] HALF_MAX_SINGLE = 31'h477F_E000;
    localparam logic [14:0] HALF_MAX_HALF   = 15'h7BFF;

    // half exponent field values
    localparam logic [4:0] HALF_EXP_ZERO = 5'd0;
    localparam logic [4:0] HALF_EXP_SPEC = 5'd31;

    // single-to-half exponent bounds
    localparam logic [7:0] SGL_EXP_SUB_MAX  = 8'd112;  // at or below: subnormal half
    localparam logic [7:0] SGL_EXP_SAT_MIN  = 8'd143;  // at or above: saturate
    localparam logic [7:0] SGL_EXP_FLUSH_LT = 8'd102;  // below: signed zero
    localparam logic [7:0] SGL_SUB_SHIFT    = 8'd126;  // subnormal shift base

    // re-bias between formats
    localparam logic [7:0] EXP_REBIAS   = 8'd112;
    localparam logic [7:0] SUB_EXP_BASE = 8'd103;

endpackage

@@ src/hfc_widen.sv @@
// hfc_widen: combinational binary16 to binary32 decode with saturation.
// Depends on hfc_pkg.
module hfc_widen (
    input  logic [15:0] i_half,
    output logic [31:0] o_single
);

    logic       sign;
    logic [4:0] h_exp;
    logic [9:0] h_man;
    logic [3:0] lead;
    logic [9:0] man_norm;
    logic [7:0] sub_exp;
    logic [7:0] nrm_exp;

    assign sign  = i_half[15];
    assign h_exp = i_half[14:10];
    assign h_man = i_half[9:0];

    // position of the leading one in a subnormal mantissa
    always_comb begin
        lead = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (h_man[i]) begin
                lead = 4'(i);
            end
        end
    end

    // move the leading one to the top bit; it becomes the hidden bit
    assign man_norm = h_man << (4'd9 - lead);
    assign sub_exp  = hfc_pkg::SUB_EXP_BASE + {4'd0, lead};
    assign nrm_exp  = {3'd0, h_exp} + hfc_pkg::EXP_REBIAS;

    // select by exponent class
    always_comb begin
        if (h_exp == hfc_pkg::HALF_EXP_ZERO) begin
            if (h_man == 10'd0) begin
                o_single = {sign, 31'd0};
            end else begin
                o_single = {sign, sub_exp, man_norm[8:0], 14'd0};
            end
        end else if (h_exp == hfc_pkg::HALF_EXP_SPEC) begin
            o_single = {sign, hfc_pkg::HALF_MAX_SINGLE};
        end else begin
            o_single = {sign, nrm_exp, h_man, 13'd0};
        end
    end

endmodule

@@ src/hfc_narrow.sv @@
// hfc_narrow: combinational binary32 to binary16 encode with saturation
// and half-up rounding of subnormals. Depends on hfc_pkg.
module hfc_narrow (
    input  logic [31:0] i_single,
    output logic [15:0] o_half
);

    logic        sign;
    logic [7:0]  f_exp;
    logic [22:0] f_man;
    logic [23:0] full;
    logic [7:0]  sh_wide;
    logic [4:0]  sh;
    logic [4:0]  sh_rnd;
    logic [23:0] shifted;
    logic [23:0] rnd_vec;
    logic [10:0] sub_mag;
    logic [4:0]  nrm_exp;
    logic [7:0]  nrm_exp_wide;

    assign sign  = i_single[31];
    assign f_exp = i_single[30:23];
    assign f_man = i_single[22:0];
    assign full  = {1'b1, f_man};

    // subnormal: shift right by 126 - exp (14..24 in range), round on top dropped bit
    assign sh_wide = hfc_pkg::SGL_SUB_SHIFT - f_exp;
    assign sh      = sh_wide[4:0];
    assign sh_rnd  = sh - 5'd1;
    assign shifted = full >> sh;
    assign rnd_vec = full >> sh_rnd;
    assign sub_mag = {1'b0, shifted[9:0]} + {10'd0, rnd_vec[0]};

    // normal range re-bias
    assign nrm_exp_wide = f_exp - hfc_pkg::EXP_REBIAS;
    assign nrm_exp      = nrm_exp_wide[4:0];

    always_comb begin
        if (f_exp <= hfc_pkg::SGL_EXP_SUB_MAX) begin
            if (f_exp < hfc_pkg::SGL_EXP_FLUSH_LT) begin
                o_half = {sign, 15'd0};
            end else begin
                o_half = {sign, 4'd0, sub_mag};
            end
        end else if (f_exp >= hfc_pkg::SGL_EXP_SAT_MIN) begin
            o_half = {sign, hfc_pkg::HALF_MAX_HALF};
        end else begin
            o_half = {sign, nrm_exp, f_man[22:13]};
        end
    end

endmodule

@@ src/half_float_converter_core.sv @@
// half_float_converter_core: top level of the binary16/binary32 converter.
// Depends on hfc_pkg, hfc_widen and hfc_narrow.
//
// Takes one item per clock cycle: busy is never raised, so start may be held
// high every cycle. Each item's result appears on o_converted with o_valid high
// for exactly one cycle, after the item has passed through one input register,
// the conversion logic and one result register. Results come out in the order
// items went in; the receiver must take o_converted whenever o_valid is high.
// A half result sits in the low 16 bits with the upper bits zero.
module half_float_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_operand,
    output logic        o_valid,
    output logic [31:0] o_converted
);

    logic        r_in_valid;
    logic        r_action;
    logic [31:0] r_operand;
    logic        r_out_valid;
    logic [31:0] r_converted;
    logic [31:0] n_converted;
    logic [31:0] wide_res;
    logic [15:0] narrow_res;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_action  <= i_action;
            r_operand <= i_operand;
        end
    end

    hfc_widen u_widen (
        .i_half   (r_operand[15:0]),
        .o_single (wide_res)
    );

    hfc_narrow u_narrow (
        .i_single (r_operand),
        .o_half   (narrow_res)
    );

    // pick direction
    assign n_converted = (r_action == hfc_pkg::ACT_NARROW) ? {16'd0, narrow_res} : wide_res;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_converted <= n_converted;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_converted = r_converted;

endmodule

@@ src/hfc_checker.sv @@
// hfc_checker: port-level assertions for half_float_converter_core.
// Depends on hfc_pkg; bound to the top level below.
module hfc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_operand,
    input  logic        o_valid,
    input  logic [31:0] o_converted
);

    // every taken item yields a result on o_valid
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("item taken without result");

    // no result without an earlier taken item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without item");

    // half results leave the upper word clear
    a_narrow_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_action == hfc_pkg::ACT_NARROW, 2))
        |-> (o_converted[31:16] == 16'd0))
        else $error("half result has upper bits set");

    // half zero widens to signed zero with matching sign
    a_widen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_action == hfc_pkg::ACT_WIDEN && i_operand[14:0] == 15'd0, 2))
        |-> (o_converted[30:0] == 31'd0 && o_converted[31] == $past(i_operand[15], 2)))
        else $error("zero widened wrongly");

endmodule

bind half_float_converter_core hfc_checker u_hfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_action    (i_action),
    .i_operand   (i_operand),
    .o_valid     (o_valid),
    .o_converted (o_converted)
);

@@ sim/tb.sv @@
// tb: self-checking bench for half_float_converter_core, both conversion directions.
// Depends on hfc_pkg and the RTL under src. Runs directed corners, then random bursts.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned IDLE_LIMIT   = 200;   // cycles with no item and no result
    localparam int unsigned DRAIN_CYCLES = 4;     // two-stage pipeline plus margin

    // one item waiting for its result
    typedef struct {
        logic        act;
        logic [31:0] operand;
        logic [31:0] word;
    } t_conv_entry;

    // predicts each conversion and checks results in order
    class t_conv_scoreboard;
        localparam logic [30:0] MAX_AS_SINGLE = 31'h477F_E000;
        localparam logic [14:0] MAX_AS_HALF   = 15'h7BFF;
        localparam int          SUB_BASE_EXP  = 103;
        localparam int          REBIAS        = 112;
        localparam int          SAT_EXP       = 143;
        localparam int          SHIFT_BASE    = 126;

        t_conv_entry pending_conv[$];
        int unsigned mismatches;
        int unsigned compared;
        int unsigned widen_items;
        int unsigned narrow_items;
        int unsigned flush_items;
        int unsigned subnorm_items;
        int unsigned sat_items;

        function logic [31:0] half_to_single(logic [15:0] h);
            logic        sgn;
            logic [4:0]  ex;
            logic [9:0]  man;
            logic [31:0] frac;
            int          lead;
            sgn = h[15];
            ex  = h[14:10];
            man = h[9:0];
            if (ex == 5'd0) begin
                if (man == 10'd0)
                    return {sgn, 31'd0};
                // normalize on the leading one, which then drops out
                lead = 0;
                for (int i = 0; i < 10; i++)
                    if (man[i])
                        lead = i;
                frac = (32'(man) << (23 - lead)) & 32'h007F_FFFF;
                return {sgn, 8'(SUB_BASE_EXP + lead), frac[22:0]};
            end
            if (ex == 5'd31)
                return {sgn, MAX_AS_SINGLE};
            return {sgn, 8'(int'(ex) + REBIAS), man, 13'd0};
        endfunction

        function logic [31:0] single_to_half(logic [31:0] f);
            logic        sgn;
            logic [7:0]  ex;
            logic [31:0] full;
            logic [31:0] mag;
            int          sh;
            sgn = f[31];
            ex  = f[30:23];
            if (int'(ex) <= REBIAS) begin
                sh = SHIFT_BASE - int'(ex);
                if (sh > 24)
                    return {16'd0, sgn, 15'd0};
                // explicit leading one, round half-up on the first dropped bit
                full = {8'd0, 1'b1, f[22:0]};
                mag  = (full >> sh) & 32'h0000_03FF;
                if (full[sh - 1])
                    mag = mag + 32'd1;
                return {16'd0, sgn, mag[14:0]};
            end
            if (int'(ex) >= SAT_EXP)
                return {16'd0, sgn, MAX_AS_HALF};
            return {16'd0, sgn, 5'(int'(ex) - REBIAS), f[22:13]};
        endfunction

        function void note_item(logic act, logic [31:0] operand);
            t_conv_entry e;
            int          ex;
            e.act     = act;
            e.operand = operand;
            if (act == hfc_pkg::ACT_WIDEN) begin
                e.word = half_to_single(operand[15:0]);
                widen_items++;
            end else begin
                e.word = single_to_half(operand);
                narrow_items++;
                ex = int'(operand[30:23]);
                if (ex < 102)
                    flush_items++;
                else if (ex <= REBIAS)
                    subnorm_items++;
                else if (ex >= SAT_EXP)
                    sat_items++;
            end
            pending_conv.push_back(e);
        endfunction

        task report(string what, logic [31:0] operand, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] %s: operand %h expected %h got %h",
                         $time, what, operand, want, got);
        endtask

        task check_result(logic [31:0] got);
            t_conv_entry e;
            if (pending_conv.size() == 0) begin
                report("unexpected result", 32'd0, 32'd0, got);
                return;
            end
            e = pending_conv.pop_front();
            compared++;
            if (got !== e.word)
                report(e.act == hfc_pkg::ACT_WIDEN ? "widen mismatch" : "narrow mismatch",
                       e.operand, e.word, got);
        endtask

        task report_leftovers();
            t_conv_entry e;
            while (pending_conv.size() != 0) begin
                e = pending_conv.pop_front();
                report("missing result", e.operand, e.word, 32'd0);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = hfc_pkg::ACT_WIDEN;
    logic [31:0] i_operand = 32'd0;
    logic        o_valid;
    logic [31:0] o_converted;

    t_conv_scoreboard sb = new;
    int unsigned      idle_cycles = 0;

    half_float_converter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_operand   (i_operand),
        .o_valid     (o_valid),
        .o_converted (o_converted)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result monitor and stall watchdog; values read here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_converted);
        if (i_rst_n && ((start && !busy) || o_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item or result for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one item and hold it until the block takes it
    task send_item(input logic act, input logic [31:0] operand);
        start     <= 1'b1;
        i_action  <= act;
        i_operand <= operand;
        do
            @(posedge i_clk);
        while (busy);
        sb.note_item(act, operand);
    endtask

    // drop start for a while, with junk on the data ports
    task pause(input int unsigned cycles);
        start     <= 1'b0;
        i_action  <= 1'($urandom_range(0, 1));
        i_operand <= $urandom();
        repeat (cycles) @(posedge i_clk);
    endtask

    // half operand with the exponent steered across zero, subnormal, normal, special
    function logic [31:0] rand_half_operand();
        logic [31:0] w;
        int unsigned pick;
        w    = $urandom();
        pick = $urandom_range(0, 9);
        if (pick < 3)
            w[14:10] = 5'd0;
        else if (pick < 5)
            w[14:10] = 5'd31;
        else if (pick == 5)
            w[14:10] = 5'($urandom_range(1, 2));
        else if (pick == 6)
            w[14:10] = 5'($urandom_range(29, 30));
        if (pick == 0 && $urandom_range(0, 1) == 0)
            w[9:0] = 10'd0;
        return w;
    endfunction

    // single operand spread over flush, subnormal, normal and saturating ranges
    function logic [31:0] rand_single_operand();
        logic [31:0] w;
        int unsigned pick;
        w    = $urandom();
        pick = $urandom_range(0, 11);
        case (pick)
            0, 1:       w[30:23] = 8'($urandom_range(0, 101));
            2, 3, 4, 5: w[30:23] = 8'($urandom_range(100, 114));
            6, 7:       w[30:23] = 8'($urandom_range(113, 142));
            8:          w[30:23] = 8'($urandom_range(141, 145));
            9:          w[30:23] = 8'($urandom_range(143, 255));
            10:         w[30:23] = 8'hFF;
            default: begin
            end
        endcase
        // mantissa of all ones drives the rounding carry
        if ($urandom_range(0, 7) == 0)
            w[22:0] = 23'h7F_FFFF;
        return w;
    endfunction

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, back to back
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_0000);   // positive zero
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_8000);   // negative zero
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_0001);   // smallest subnormal
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_83FF);   // largest subnormal, negative
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_0200);   // subnormal, top bit only
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_0400);   // smallest normal
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_7BFF);   // largest normal
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_7C00);   // infinity
        send_item(hfc_pkg::ACT_WIDEN, 32'h0000_FE01);   // negative NaN
        send_item(hfc_pkg::ACT_WIDEN, 32'hFFFF_3C00);   // upper bits must be ignored
        send_item(hfc_pkg::ACT_NARROW, 32'h0000_0000);  // positive zero
        send_item(hfc_pkg::ACT_NARROW, 32'h8000_0000);  // negative zero
        send_item(hfc_pkg::ACT_NARROW, 32'h0000_0001);  // single subnormal flushes
        send_item(hfc_pkg::ACT_NARROW, 32'h32FF_FFFF);  // exponent 101, just below range
        send_item(hfc_pkg::ACT_NARROW, 32'h3300_0000);  // exponent 102 rounds up to one
        send_item(hfc_pkg::ACT_NARROW, 32'h3380_1000);  // subnormal, dropped bit clear
        send_item(hfc_pkg::ACT_NARROW, 32'hB87F_FFFF);  // exponent 112, carry into min normal
        send_item(hfc_pkg::ACT_NARROW, 32'h3880_0000);  // exponent 113, smallest normal
        send_item(hfc_pkg::ACT_NARROW, 32'h477F_FFFF);  // exponent 142, truncated
        send_item(hfc_pkg::ACT_NARROW, 32'h4780_0000);  // exponent 143 saturates
        send_item(hfc_pkg::ACT_NARROW, 32'hFF80_0000);  // negative infinity
        send_item(hfc_pkg::ACT_NARROW, 32'h7FC0_0001);  // NaN saturates
        send_item(hfc_pkg::ACT_NARROW, 32'hFFFF_FFFF);  // all ones
        send_item(hfc_pkg::ACT_WIDEN, 32'hFFFF_FFFF);   // all ones, half view

        // random bursts with random gaps; some bursts run straight on
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int unsigned b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                if ($urandom_range(0, 1) == 0)
                    send_item(hfc_pkg::ACT_WIDEN, rand_half_operand());
                else
                    send_item(hfc_pkg::ACT_NARROW, rand_single_operand());
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
                pause(gap);
        end

        // let the pipeline empty
        start <= 1'b0;
        while (sb.pending_conv.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.report_leftovers();

        $display("ran %0d widen and %0d narrow items, %0d results compared",
                 sb.widen_items, sb.narrow_items, sb.compared);
        $display("narrow ranges hit: %0d flushed, %0d subnormal, %0d saturated",
                 sb.flush_items, sb.subnorm_items, sb.sat_items);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/hfc_pkg.sv
src/hfc_widen.sv
src/hfc_narrow.sv
src/half_float_converter_core.sv
src/hfc_checker.sv
sim/tb.sv
